[src/kgc_pkg.sv]
// ----------------------------------------------------------------------------
// kgc_pkg: shared definitions for the key gesture classifier
// state codes, gesture codes, register map and register reset values
// ----------------------------------------------------------------------------
package kgc_pkg;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_RELEASED  = 3'd0;
  localparam logic [STATE_W-1:0] ST_SHORT     = 3'd1;
  localparam logic [STATE_W-1:0] ST_SHORT_REL = 3'd2;
  localparam logic [STATE_W-1:0] ST_LONG      = 3'd3;
  localparam logic [STATE_W-1:0] ST_DOUBLE    = 3'd4;

  localparam int EVENT_W = 2;
  localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;

  localparam int CFG_W   = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic REG_LONG_PRESS   = 1'b0;
  localparam logic REG_DOUBLE_CLICK = 1'b1;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 8'd30;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 8'd8;

endpackage

[src/key_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// key_gesture_classifier: short, long and double-click detector for one key
// one key level word per scan tick in, zero or one gesture word out
// ----------------------------------------------------------------------------
// Input channel: in_valid, in_stall, key_pressed. One word per scan tick.
// Output channel: out_valid, out_stall, gesture_event (0 short, 1 long,
// 2 double click). Ticks that finish no gesture give no output word.
// An accepted word is held in an input register; once the classify step is
// free, the state machine and tick counter update and a gesture, if any, is
// loaded into the output register. The block takes one word per cycle while
// the output is not stalled.
// A stalled output word blocks the classify step only; the input register
// still takes one word, and in_stall rises only when that word is waiting
// behind a stalled gesture.
// The APB-style port sets long_press_ticks (address 0) and
// double_click_ticks (address 4); write them only while the block is idle.
// Reset (rst, synchronous) clears the state to released, the counter to
// zero, both channels to empty and the registers to 30 and 8.
// ----------------------------------------------------------------------------
module key_gesture_classifier #(
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          key_pressed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kgc_pkg::EVENT_W-1:0]   gesture_event,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgc_pkg::ADDR_W-1:0]    paddr,
  input  logic [kgc_pkg::DATA_W-1:0]    pwdata,
  output logic [kgc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int CMP_W = (COUNT_BITS > kgc_pkg::CFG_W) ? COUNT_BITS : kgc_pkg::CFG_W;

  logic [kgc_pkg::CFG_W-1:0]   long_press_ticks;
  logic [kgc_pkg::CFG_W-1:0]   double_click_ticks;
  logic [kgc_pkg::STATE_W-1:0] state;
  logic [kgc_pkg::STATE_W-1:0] state_next;
  logic [COUNT_BITS-1:0]       tick_count;
  logic [COUNT_BITS-1:0]       tick_count_next;
  logic                        hold_valid;
  logic                        hold_key;
  logic                        proc;
  logic                        ev_hit;
  logic [kgc_pkg::EVENT_W-1:0] ev_code;
  logic [COUNT_BITS-1:0]       bumped;
  logic [CMP_W-1:0]            bumped_x;
  logic                        over_long;
  logic                        over_double;
  logic                        cfg_wr;
  logic                        reg_sel;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks   <= kgc_pkg::LONG_PRESS_RESET;
      double_click_ticks <= kgc_pkg::DOUBLE_CLICK_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == kgc_pkg::REG_LONG_PRESS) begin
        long_press_ticks <= pwdata[kgc_pkg::CFG_W-1:0];
      end else begin
        double_click_ticks <= pwdata[kgc_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == kgc_pkg::REG_LONG_PRESS) begin
      prdata[kgc_pkg::CFG_W-1:0] = long_press_ticks;
    end else begin
      prdata[kgc_pkg::CFG_W-1:0] = double_click_ticks;
    end
  end

  // input register
  assign proc     = hold_valid && !(out_valid && out_stall);
  assign in_stall = hold_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (proc) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_key <= key_pressed;
    end
  end

  // classify step
  assign bumped      = (&tick_count) ? tick_count : tick_count + COUNT_BITS'(1);
  assign bumped_x    = CMP_W'(bumped);
  assign over_long   = bumped_x > CMP_W'(long_press_ticks);
  assign over_double = bumped_x > CMP_W'(double_click_ticks);

  always_comb begin
    state_next      = state;
    tick_count_next = tick_count;
    ev_hit          = 1'b0;
    ev_code         = kgc_pkg::EV_SHORT;
    if (hold_key) begin
      unique case (state)
        kgc_pkg::ST_SHORT: begin
          tick_count_next = bumped;
          if (over_long) begin
            state_next = kgc_pkg::ST_LONG;
            ev_hit     = 1'b1;
            ev_code    = kgc_pkg::EV_LONG;
          end
        end
        kgc_pkg::ST_SHORT_REL: begin
          tick_count_next = bumped;
          state_next      = kgc_pkg::ST_DOUBLE;
          ev_hit          = 1'b1;
          ev_code         = kgc_pkg::EV_DOUBLE;
        end
        kgc_pkg::ST_LONG, kgc_pkg::ST_DOUBLE: begin
          tick_count_next = bumped;
        end
        default: begin
          state_next      = kgc_pkg::ST_SHORT;
          tick_count_next = '0;
        end
      endcase
    end else begin
      unique case (state)
        kgc_pkg::ST_SHORT, kgc_pkg::ST_SHORT_REL: begin
          if (over_double) begin
            state_next      = kgc_pkg::ST_RELEASED;
            tick_count_next = '0;
            ev_hit          = 1'b1;
            ev_code         = kgc_pkg::EV_SHORT;
          end else begin
            state_next      = kgc_pkg::ST_SHORT_REL;
            tick_count_next = bumped;
          end
        end
        kgc_pkg::ST_LONG, kgc_pkg::ST_DOUBLE: begin
          state_next      = kgc_pkg::ST_RELEASED;
          tick_count_next = '0;
        end
        default: begin
          state_next = kgc_pkg::ST_RELEASED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kgc_pkg::ST_RELEASED;
      tick_count <= '0;
    end else if (proc) begin
      state      <= state_next;
      tick_count <= tick_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && ev_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && ev_hit) begin
      gesture_event <= ev_code;
    end
  end

  // checks
  a_released_count_zero: assert property (@(posedge clk) disable iff (rst)
    (state == kgc_pkg::ST_RELEASED) |-> (tick_count == '0))
    else $error("counter not cleared in released state");

  a_long_enters_long: assert property (@(posedge clk) disable iff (rst)
    (proc && ev_hit && ev_code == kgc_pkg::EV_LONG) |=>
      (state == kgc_pkg::ST_LONG && out_valid && gesture_event == kgc_pkg::EV_LONG))
    else $error("long press event without long press state");

  a_double_enters_double: assert property (@(posedge clk) disable iff (rst)
    (proc && ev_hit && ev_code == kgc_pkg::EV_DOUBLE) |=>
      (state == kgc_pkg::ST_DOUBLE))
    else $error("double click event without double click state");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && !proc))
    else $error("input stalled while classify step is free");

  a_held_state_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !proc) |=> ($stable(state) && $stable(tick_count)))
    else $error("state moved while output word was stalled");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the key gesture classifier
// a queue-fed driver sends key level words with random gaps, a monitor
// predicts the gesture words from each accepted level and checks them in
// order against the output channel, which stalls at random. the register
// port is read at its reset values first, then written between phases,
// covering 0, 254 and random settings, and each write is read back.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CNT_W       = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic key_pressed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [kgc_pkg::EVENT_W-1:0] gesture_event;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [kgc_pkg::ADDR_W-1:0] paddr = '0;
  logic [kgc_pkg::DATA_W-1:0] pwdata = '0;
  logic [kgc_pkg::DATA_W-1:0] prdata;
  logic pready;

  key_gesture_classifier #(.COUNT_BITS(CNT_W)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .key_pressed(key_pressed),
    .out_valid(out_valid), .out_stall(out_stall), .gesture_event(gesture_event),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // classifier mirror
  logic [kgc_pkg::STATE_W-1:0] gst_state = kgc_pkg::ST_RELEASED;
  logic [CNT_W-1:0]            gst_count = '0;
  logic [kgc_pkg::CFG_W-1:0]   long_limit = kgc_pkg::LONG_PRESS_RESET;
  logic [kgc_pkg::CFG_W-1:0]   dbl_window = kgc_pkg::DOUBLE_CLICK_RESET;

  logic                        key_q[$];
  logic [kgc_pkg::EVENT_W-1:0] gesture_q[$];
  int  words_queued = 0;
  int  words_taken = 0;
  int  cycles = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  bit  failed = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic classify_tick(input logic key);
    logic                        fired;
    logic [kgc_pkg::EVENT_W-1:0] ev;
    fired = 1'b0;
    ev = kgc_pkg::EV_SHORT;
    if (gst_state > kgc_pkg::ST_DOUBLE) gst_state = kgc_pkg::ST_RELEASED;
    if (key) begin
      if (gst_count != '1) gst_count++;
      case (gst_state)
        kgc_pkg::ST_RELEASED: begin
          gst_state = kgc_pkg::ST_SHORT;
          gst_count = '0;
        end
        kgc_pkg::ST_SHORT: begin
          if (gst_count > long_limit) begin
            gst_state = kgc_pkg::ST_LONG;
            ev = kgc_pkg::EV_LONG;
            fired = 1'b1;
          end
        end
        kgc_pkg::ST_SHORT_REL: begin
          gst_state = kgc_pkg::ST_DOUBLE;
          ev = kgc_pkg::EV_DOUBLE;
          fired = 1'b1;
        end
        default: ;
      endcase
    end else begin
      if (gst_state != kgc_pkg::ST_RELEASED && gst_count != '1) gst_count++;
      if (gst_state == kgc_pkg::ST_SHORT && gst_count <= dbl_window) begin
        gst_state = kgc_pkg::ST_SHORT_REL;
      end else if (gst_state == kgc_pkg::ST_SHORT ||
                   (gst_state == kgc_pkg::ST_SHORT_REL && gst_count > dbl_window)) begin
        ev = kgc_pkg::EV_SHORT;
        fired = 1'b1;
      end
      if (fired || gst_state == kgc_pkg::ST_LONG || gst_state == kgc_pkg::ST_DOUBLE) begin
        gst_state = kgc_pkg::ST_RELEASED;
        gst_count = '0;
      end
    end
    if (fired) gesture_q.push_back(ev);
  endtask

  // monitor: outputs checked against the oldest expected gesture
  always @(posedge clk) begin
    logic [kgc_pkg::EVENT_W-1:0] want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (gesture_q.size() == 0) begin
          $error("gesture_event: expected none, got %0d", gesture_event);
          failed = 1'b1;
        end else begin
          want = gesture_q.pop_front();
          if (gesture_event !== want) begin
            $error("gesture_event: expected %0d, got %0d", want, gesture_event);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        words_taken++;
        classify_tick(key_pressed);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (key_q.size() != 0) begin
        key_pressed <= key_q.pop_front();
        in_valid <= 1'b1;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      rx_wait = HOLD_CYCLES;
    end
    if (out_taken && rx_wait == 0) rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
  end

  task automatic reg_read(input logic idx, input logic [kgc_pkg::CFG_W-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[kgc_pkg::CFG_W-1:0] !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata[kgc_pkg::CFG_W-1:0]);
      failed = 1'b1;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic idx, input int val);
    logic [kgc_pkg::DATA_W-1:0] word;
    word = ($urandom & ~32'hFF) | (val & 32'hFF);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == kgc_pkg::REG_LONG_PRESS) long_limit = word[kgc_pkg::CFG_W-1:0];
    else dbl_window = word[kgc_pkg::CFG_W-1:0];
    reg_read(idx, word[kgc_pkg::CFG_W-1:0]);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (words_taken != words_queued || gesture_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_keys(input logic level, input int n);
    repeat (n) begin
      key_q.push_back(level);
      words_queued++;
    end
  endtask

  function automatic int near(input int x);
    int t;
    t = x + int'($urandom_range(0, 4)) - 2;
    return (t < 1) ? 1 : t;
  endfunction

  task automatic add_gesture();
    int lp;
    int dc;
    lp = long_limit;
    dc = dbl_window;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        add_keys(1'b1, near(dc));
        add_keys(1'b0, near(dc));
      end
      3, 4: begin
        add_keys(1'b1, $urandom_range(1, dc + 1));
        add_keys(1'b0, $urandom_range(1, dc + 1));
        add_keys(1'b1, $urandom_range(1, 4));
        add_keys(1'b0, $urandom_range(1, 3));
      end
      5, 6: begin
        add_keys(1'b1, near(lp + 1));
        add_keys(1'b0, $urandom_range(1, 3));
      end
      7: begin
        add_keys(1'b1, lp + $urandom_range(2, 60));
        add_keys(1'b0, $urandom_range(1, dc + 2));
      end
      default: begin
        repeat ($urandom_range(1, 8)) add_keys(1'($urandom_range(0, 1)), 1);
      end
    endcase
  endtask

  task automatic add_random(input int n);
    int stop;
    stop = words_queued + n;
    while (words_queued < stop) add_gesture();
  endtask

  task automatic set_limits(input int lp, input int dc);
    wait_idle();
    reg_write(kgc_pkg::REG_LONG_PRESS, lp);
    reg_write(kgc_pkg::REG_DOUBLE_CLICK, dc);
    @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reg_read(kgc_pkg::REG_LONG_PRESS, kgc_pkg::LONG_PRESS_RESET);
    reg_read(kgc_pkg::REG_DOUBLE_CLICK, kgc_pkg::DOUBLE_CLICK_RESET);
    @(posedge clk);
    add_random(120);

    set_limits(3, 2);
    // short after the wait runs out, including the window edge
    add_keys(1'b1, 1);
    add_keys(1'b0, 3);
    // double click
    add_keys(1'b1, 2);
    add_keys(1'b0, 1);
    add_keys(1'b1, 1);
    add_keys(1'b0, 1);
    // long press held on, release gives nothing
    add_keys(1'b1, 6);
    add_keys(1'b0, 1);
    // release after the window: short at once
    add_keys(1'b1, 3);
    add_keys(1'b0, 1);
    add_random(60);

    set_limits(0, 0);
    hold_req = 1'b1;
    add_random(80);

    set_limits(254, 254);
    // long press held up to the counter ceiling
    add_keys(1'b1, 258);
    add_keys(1'b0, 1);
    // double click inside the widest window
    add_keys(1'b1, 1);
    add_keys(1'b0, 1);
    add_keys(1'b1, 1);
    add_keys(1'b0, 1);

    set_limits(0, 254);
    add_keys(1'b1, 1);
    add_keys(1'b0, 2);
    add_keys(1'b1, 1);
    add_keys(1'b0, 1);
    add_keys(1'b1, 3);
    add_keys(1'b0, 1);

    set_limits(254, 0);
    add_keys(1'b1, 1);
    add_keys(1'b0, 1);
    add_keys(1'b1, 4);
    add_keys(1'b0, 1);

    repeat (3) begin
      set_limits($urandom_range(0, 40), $urandom_range(0, 20));
      add_random(50);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
